// ----- src/scsw_pkg.sv -----
`default_nettype none

package scsw_pkg;

	// Frame sequencer phases, one-hot
	typedef enum logic [13:0] {
		PH_IDLE  = 14'b00000000000001,
		PH_ST_A  = 14'b00000000000010,
		PH_ST_B  = 14'b00000000000100,
		PH_B1_LO = 14'b00000000001000,
		PH_B1_HI = 14'b00000000010000,
		PH_K1_LO = 14'b00000000100000,
		PH_K1_HI = 14'b00000001000000,
		PH_B2_LO = 14'b00000010000000,
		PH_B2_HI = 14'b00000100000000,
		PH_K2_LO = 14'b00001000000000,
		PH_K2_HI = 14'b00010000000000,
		PH_SP_A  = 14'b00100000000000,
		PH_SP_B  = 14'b01000000000000,
		PH_SP_C  = 14'b10000000000000
	} phase_t;

	// Input command codes, carried on s_tuser
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SHOW = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_DATA_CMD  = 3'd0;
	localparam logic [2:0] REG_ADDR_0    = 3'd1;
	localparam logic [2:0] REG_ADDR_1    = 3'd2;
	localparam logic [2:0] REG_ADDR_2    = 3'd3;
	localparam logic [2:0] REG_ADDR_3    = 3'd4;
	localparam logic [2:0] REG_DISP_CMD  = 3'd5;
	localparam logic [2:0] REG_HALF_BIT  = 3'd6;

	localparam logic [7:0]  RST_DATA_CMD = 8'h40;
	localparam logic [7:0]  RST_ADDR_0   = 8'hC0;
	localparam logic [7:0]  RST_ADDR_1   = 8'hC1;
	localparam logic [7:0]  RST_ADDR_2   = 8'hC2;
	localparam logic [7:0]  RST_ADDR_3   = 8'hC3;
	localparam logic [7:0]  RST_DISP_CMD = 8'h88;
	localparam logic [15:0] RST_HALF_BIT = 16'd1;

	localparam int unsigned WAIT_BITS_DEF = 16;

	localparam logic [2:0] LAST_FRAME = 3'd5;
	localparam logic [7:0] COLON_BIT  = 8'h80;
	localparam logic [6:0] MAX_NUMBER = 7'd99;

	// Decimal digit to seven-segment code
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0: c = 8'h3f;
			4'd1: c = 8'h06;
			4'd2: c = 8'h5b;
			4'd3: c = 8'h4f;
			4'd4: c = 8'h66;
			4'd5: c = 8'h6d;
			4'd6: c = 8'h7d;
			4'd7: c = 8'h07;
			4'd8: c = 8'h7f;
			4'd9: c = 8'h6f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Tens digit of 0..99 by reciprocal multiply: v*205 >> 11
	function automatic logic [3:0] tens_digit(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

endpackage

`default_nettype wire

// ----- src/segment_clock_serial_writer_unit.sv -----
`default_nettype none

// Two-wire seven-segment display writer.
//
// Input stream (s_*): each transfer is either a time tick (s_tuser = 0) or a
// request to show a new time (s_tuser = 1) with two numbers in s_tdata.
// A request while idle captures four segment codes (colon set on the second
// digit) and starts six frames: data command, four address/segment pairs and
// the display command. Each line change is held for half_bit_ticks ticks.
// A request while busy is dropped and flagged as rejected.
// Output stream (m_*): exactly one result per input transfer, holding the
// clock and data line levels after that item, busy and rejected.
// Each result is registered, in the skid stage if the output register still
// holds an unaccepted one. Throughput: one item per cycle while s_tready is
// high; the step logic is a single registered pass over the sequencer state.
// The output register is backed by a one-entry skid stage, so one input is
// still taken while a result waits; s_tready drops only when both are full.
// Reset: idle, both lines high, configuration at its defaults, no result
// pending. cfg_* writes take effect at once and must only happen while idle.

module segment_clock_serial_writer_unit
	import scsw_pkg::*;
#(
	parameter int unsigned WAIT_COUNT_BITS = WAIT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [6:0] left_number, [13:7] right_number, [15:14] zero
	input  wire logic        s_tuser,  // command: 0 tick, 1 show request
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // [0] clock_pin, [1] data_pin, [2] busy_res,
	                                   // [3] rejected, [7:4] zero
);

	localparam logic [31:0] WAIT_MAX =
		32'((64'd1 << WAIT_COUNT_BITS) - 64'd1);

	// configuration registers
	logic [7:0]  data_cmd_q, addr0_q, addr1_q, addr2_q, addr3_q, disp_cmd_q;
	logic [15:0] half_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_cmd_q <= RST_DATA_CMD;
			addr0_q    <= RST_ADDR_0;
			addr1_q    <= RST_ADDR_1;
			addr2_q    <= RST_ADDR_2;
			addr3_q    <= RST_ADDR_3;
			disp_cmd_q <= RST_DISP_CMD;
			half_bit_q <= RST_HALF_BIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DATA_CMD: data_cmd_q <= cfg_data[7:0];
				REG_ADDR_0:   addr0_q    <= cfg_data[7:0];
				REG_ADDR_1:   addr1_q    <= cfg_data[7:0];
				REG_ADDR_2:   addr2_q    <= cfg_data[7:0];
				REG_ADDR_3:   addr3_q    <= cfg_data[7:0];
				REG_DISP_CMD: disp_cmd_q <= cfg_data[7:0];
				REG_HALF_BIT: half_bit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// wait reload: zero acts as one, saturate to counter range
	logic [31:0]                reload_wide;
	logic [WAIT_COUNT_BITS-1:0] reload;

	always_comb begin
		reload_wide = {16'd0, half_bit_q};
		if (reload_wide == 32'd0) reload_wide = 32'd1;
		if (reload_wide > WAIT_MAX) reload_wide = WAIT_MAX;
		reload = reload_wide[WAIT_COUNT_BITS-1:0];
	end

	// sequencer state
	phase_t                     phase_q, phase_d;
	logic [2:0]                 frame_q, frame_d;
	logic [3:0]                 bit_q, bit_d;
	logic [7:0]                 shift_q, shift_d;
	logic [WAIT_COUNT_BITS-1:0] wait_q, wait_d, wait_dec;
	logic                       clk_lvl_q, clk_lvl_d;
	logic                       dat_lvl_q, dat_lvl_d;
	logic [7:0]                 seg_q [4];

	logic       accept;
	logic       busy;
	logic       rej;
	logic       seg_load;
	logic       enter_en;
	logic [6:0] left_sat, right_sat;
	logic [3:0] left_tens, right_tens, left_ones, right_ones;
	logic [6:0] left_rem, right_rem;
	logic [2:0] frame_m1;
	logic [3:0] bit_inc;

	assign accept = s_tvalid & s_tready;
	assign busy   = (phase_q != PH_IDLE);

	// digit split of the saturated numbers
	always_comb begin
		left_sat   = (s_tdata[6:0]  > MAX_NUMBER) ? MAX_NUMBER : s_tdata[6:0];
		right_sat  = (s_tdata[13:7] > MAX_NUMBER) ? MAX_NUMBER : s_tdata[13:7];
		left_tens  = tens_digit(left_sat);
		right_tens = tens_digit(right_sat);
		left_rem   = left_sat  - 7'(left_tens)  * 7'd10;
		right_rem  = right_sat - 7'(right_tens) * 7'd10;
		left_ones  = left_rem[3:0];
		right_ones = right_rem[3:0];
	end

	assign frame_m1 = frame_q - 3'd1;
	assign bit_inc  = bit_q + 4'd1;
	assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

	// one step of the frame sequencer
	always_comb begin
		phase_d   = phase_q;
		frame_d   = frame_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		wait_d    = wait_q;
		clk_lvl_d = clk_lvl_q;
		dat_lvl_d = dat_lvl_q;
		rej       = 1'b0;
		seg_load  = 1'b0;
		enter_en  = 1'b0;

		if (s_tuser == CMD_SHOW) begin
			if (busy) begin
				rej = 1'b1;
			end else begin
				seg_load = 1'b1;
				frame_d  = 3'd0;
				bit_d    = 4'd0;
				phase_d  = PH_ST_A;
				enter_en = 1'b1;
			end
		end else if (busy) begin
			wait_d = wait_dec;
			if (wait_dec == '0) begin
				enter_en = 1'b1;
				case (phase_q)
					PH_ST_A: phase_d = PH_ST_B;
					PH_ST_B: begin
						case (frame_q)
							3'd0: shift_d = data_cmd_q;
							3'd1: shift_d = addr0_q;
							3'd2: shift_d = addr1_q;
							3'd3: shift_d = addr2_q;
							3'd4: shift_d = addr3_q;
							default: shift_d = disp_cmd_q;
						endcase
						bit_d   = 4'd0;
						phase_d = PH_B1_LO;
					end
					PH_B1_LO: phase_d = PH_B1_HI;
					PH_B2_LO: phase_d = PH_B2_HI;
					PH_B1_HI: begin
						shift_d = {1'b0, shift_q[7:1]};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= 4'd8) ? PH_K1_LO : PH_B1_LO;
					end
					PH_B2_HI: begin
						shift_d = {1'b0, shift_q[7:1]};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= 4'd8) ? PH_K2_LO : PH_B2_LO;
					end
					PH_K1_LO: phase_d = PH_K1_HI;
					PH_K2_LO: phase_d = PH_K2_HI;
					PH_K1_HI: begin
						// address frames carry a segment byte after the address
						if (frame_q >= 3'd1 && frame_q <= 3'd4) begin
							shift_d = seg_q[frame_m1[1:0]];
							bit_d   = 4'd0;
							phase_d = PH_B2_LO;
						end else begin
							phase_d = PH_SP_A;
						end
					end
					PH_K2_HI: phase_d = PH_SP_A;
					PH_SP_A:  phase_d = PH_SP_B;
					PH_SP_B:  phase_d = PH_SP_C;
					PH_SP_C: begin
						if (frame_q >= LAST_FRAME) begin
							frame_d  = 3'd0;
							wait_d   = '0;
							phase_d  = PH_IDLE;
							enter_en = 1'b0;
						end else begin
							frame_d = frame_q + 3'd1;
							phase_d = PH_ST_A;
						end
					end
					default: begin
						phase_d  = PH_IDLE;
						wait_d   = '0;
						enter_en = 1'b0;
					end
				endcase
			end
		end

		// line levels on entry into the new phase
		if (enter_en) begin
			wait_d = reload;
			case (phase_d)
				PH_ST_A: begin
					clk_lvl_d = 1'b1;
					dat_lvl_d = 1'b1;
				end
				PH_ST_B: dat_lvl_d = 1'b0;
				PH_B1_LO, PH_B2_LO, PH_K1_LO, PH_K2_LO: clk_lvl_d = 1'b0;
				PH_B1_HI, PH_B2_HI: begin
					dat_lvl_d = shift_d[0];
					clk_lvl_d = 1'b1;
				end
				PH_K1_HI, PH_K2_HI: clk_lvl_d = 1'b1;
				PH_SP_A: begin
					clk_lvl_d = 1'b0;
					dat_lvl_d = 1'b0;
				end
				PH_SP_B: clk_lvl_d = 1'b1;
				PH_SP_C: dat_lvl_d = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			frame_q   <= 3'd0;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			wait_q    <= '0;
			clk_lvl_q <= 1'b1;
			dat_lvl_q <= 1'b1;
		end else if (accept) begin
			phase_q   <= phase_d;
			frame_q   <= frame_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			clk_lvl_q <= clk_lvl_d;
			dat_lvl_q <= dat_lvl_d;
		end
	end

	// segment codes, written on every accepted request while idle
	always_ff @(posedge clk) begin
		if (accept && seg_load) begin
			seg_q[0] <= seg_code(left_tens);
			seg_q[1] <= seg_code(left_ones) | COLON_BIT;
			seg_q[2] <= seg_code(right_tens);
			seg_q[3] <= seg_code(right_ones);
		end
	end

	// result register plus skid stage
	logic [7:0] result;
	logic [7:0] out_q, skid_q;
	logic       out_vld_q, skid_vld_q;
	logic       out_free;

	assign result   = {4'd0, rej, (phase_d != PH_IDLE), dat_lvl_d, clk_lvl_d};
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
			if (!out_free) skid_vld_q <= 1'b1;
		end else if (out_vld_q && m_tready) begin
			if (skid_vld_q) skid_vld_q <= 1'b0;
			else out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_free) out_q <= result;
			else skid_q <= result;
		end else if (out_vld_q && m_tready && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

endmodule

`default_nettype wire
